/* hdl/lcdns_pkg.sv */
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer package
// Shared widths, codes, word types and the set-up command table.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned SegW    = 5;
  localparam int unsigned CmdIdxW = 3;
  localparam int unsigned CfgIdxW = 8;

  localparam int unsigned LcdnsQueueDepth = 2;

  localparam logic [HoldW-1:0] PulseResetUs      = 16'd40;
  localparam logic [HoldW-1:0] CmdSettleResetUs  = 16'd5000;
  localparam logic [HoldW-1:0] DataSettleResetUs = 16'd2000;
  localparam logic [HoldW-1:0] PowerUpResetUs    = 16'd20000;

  localparam logic [CfgIdxW-1:0] CfgIdxPulse      = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxCmdSettle  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxDataSettle = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxPowerUp    = 8'd3;

  localparam logic [SegW-1:0] SegFirst      = 5'd0;
  localparam logic [SegW-1:0] ByteLastSeg   = 5'd3;
  localparam logic [SegW-1:0] InitLastSeg   = 5'd25;
  localparam logic [NibW-1:0] ClearLowNib   = 4'h1;
  localparam logic [NibW-1:0] PowerUpNib    = 4'h0;

  localparam logic [1:0] PhaseHiPulse = 2'd0;
  localparam logic [1:0] PhaseHiGap   = 2'd1;
  localparam logic [1:0] PhaseLoPulse = 2'd2;

  typedef enum logic [ModeW-1:0] {
    MODE_INIT = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_DATA = 2'd2
  } lcdns_mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lcdns_state_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ByteW-1:0] byte_value;
  } lcdns_in_t;

  typedef struct packed {
    logic             reg_select;
    logic             enable;
    logic [NibW-1:0]  nibble;
    logic [HoldW-1:0] hold_us;
    logic             last;
  } lcdns_out_t;

  typedef struct packed {
    lcdns_mode_e      kind;
    logic [ByteW-1:0] byte_value;
  } lcdns_job_t;

  typedef struct packed {
    logic [HoldW-1:0] pulse_us;
    logic [HoldW-1:0] command_settle_us;
    logic [HoldW-1:0] data_settle_us;
    logic [HoldW-1:0] power_up_us;
  } lcdns_cfg_t;

  // Four-bit interface set-up: three wake-ups, 4-bit mode, display on, clear.
  function automatic logic [ByteW-1:0] init_cmd(input logic [CmdIdxW-1:0] idx);
    logic [ByteW-1:0] cmd;
    case (idx)
      3'd0:    cmd = 8'h33;
      3'd1:    cmd = 8'h33;
      3'd2:    cmd = 8'h32;
      3'd3:    cmd = 8'h28;
      3'd4:    cmd = 8'h0C;
      default: cmd = 8'h01;
    endcase
    return cmd;
  endfunction

endpackage

/* hdl/lcdns_front.sv */
// ----------------------------------------------------------------------------
// Request front end
// Accepts request words, drops the unused mode and queues the rest as jobs.
// ----------------------------------------------------------------------------
module lcdns_front import lcdns_pkg::*; (
  input  logic       in_valid_i,
  input  lcdns_in_t  in_data_i,
  output logic       in_stall_o,
  input  logic       q_full_i,
  output logic       push_o,
  output lcdns_job_t push_data_o
);

  logic keep;

  always_comb begin
    keep                   = 1'b1;
    push_data_o.kind       = MODE_INIT;
    push_data_o.byte_value = in_data_i.byte_value;
    case (in_data_i.mode)
      MODE_INIT: push_data_o.kind = MODE_INIT;
      MODE_CMD:  push_data_o.kind = MODE_CMD;
      MODE_DATA: push_data_o.kind = MODE_DATA;
      default:   keep = 1'b0;
    endcase
  end

  // A request word is taken whenever the queue has room, even one that is dropped.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && keep;

endmodule

/* hdl/lcdns_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Small first-in first-out buffer between the front end and the sequencer.
// ----------------------------------------------------------------------------
module lcdns_queue import lcdns_pkg::*; #(
  parameter int unsigned Depth = LcdnsQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lcdns_job_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output lcdns_job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  lcdns_job_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/lcdns_back.sv */
// ----------------------------------------------------------------------------
// Segment sequencer
// Expands one job per pass into pin segments, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module lcdns_back import lcdns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lcdns_cfg_t cfg_i,
  input  logic       job_valid_i,
  input  lcdns_job_t job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output lcdns_out_t out_data_o,
  input  logic       out_stall_i
);

  lcdns_state_e   state_q, state_d;
  lcdns_job_t     job_q;
  logic [SegW-1:0] seg_q;
  lcdns_out_t     out_q;
  logic           out_valid_q;

  logic           can_adv;
  logic           emit;
  logic           seg_is_last;
  lcdns_out_t     seg_word;
  logic [SegW-1:0] pos;
  logic [ByteW-1:0] cur_byte;
  logic [HoldW-1:0] settle;
  logic           rs;

  assign can_adv = !out_valid_q || !out_stall_i;

  // Segment decode. Initialise has a leading power-up wait, so its byte
  // segments are counted from one.
  always_comb begin
    pos      = seg_q;
    cur_byte = job_q.byte_value;
    settle   = cfg_i.command_settle_us;
    rs       = 1'b0;
    case (job_q.kind)
      MODE_INIT: begin
        pos      = seg_q - 1'b1;
        cur_byte = init_cmd(pos[SegW-1:2]);
      end
      MODE_DATA: begin
        settle = cfg_i.data_settle_us;
        rs     = 1'b1;
      end
      default: begin
      end
    endcase

    seg_word.reg_select = rs;
    seg_word.last       = 1'b0;
    case (pos[1:0])
      PhaseHiPulse: begin
        seg_word.enable  = 1'b1;
        seg_word.nibble  = cur_byte[ByteW-1:NibW];
        seg_word.hold_us = cfg_i.pulse_us;
      end
      PhaseHiGap: begin
        seg_word.enable  = 1'b0;
        seg_word.nibble  = cur_byte[ByteW-1:NibW];
        seg_word.hold_us = cfg_i.pulse_us;
      end
      PhaseLoPulse: begin
        seg_word.enable  = 1'b1;
        seg_word.nibble  = cur_byte[NibW-1:0];
        seg_word.hold_us = cfg_i.pulse_us;
      end
      default: begin
        seg_word.enable  = 1'b0;
        seg_word.nibble  = cur_byte[NibW-1:0];
        seg_word.hold_us = settle;
        seg_word.last    = (job_q.kind != MODE_INIT);
      end
    endcase

    if (job_q.kind == MODE_INIT) begin
      seg_is_last = (seg_q == InitLastSeg);
      if (seg_q == SegFirst) begin
        seg_word.enable  = 1'b0;
        seg_word.nibble  = PowerUpNib;
        seg_word.hold_us = cfg_i.power_up_us;
      end else if (seg_is_last) begin
        // Clear wait keeps the pins of the clear command's low nibble.
        seg_word.enable  = 1'b0;
        seg_word.nibble  = ClearLowNib;
        seg_word.hold_us = cfg_i.power_up_us;
        seg_word.last    = 1'b1;
      end
    end else begin
      seg_is_last = (seg_q == ByteLastSeg);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (can_adv && seg_is_last && !job_valid_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    case (state_q)
      ST_IDLE: pop_o = job_valid_i;
      ST_RUN: begin
        emit  = can_adv;
        pop_o = can_adv && seg_is_last && job_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        seg_q <= '0;
      end else if (emit) begin
        seg_q <= seg_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= seg_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/char_lcd_nibble_sequencer.sv */
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer
// Turns initialise, command and data requests into timed 4-bit pin segments.
// ----------------------------------------------------------------------------
// A command or data byte becomes four output words, an initialise request
// becomes 26, and the sequencer hands out one word per cycle while the
// output side keeps up. The single segment sequencer starts the next queued
// request as soon as the final word of the current one is handed out. A
// request with the unused mode code is taken and yields no words. Requests
// are taken into a short queue whenever it has room, so the input side
// keeps moving while the output is stalled. The timing registers are
// written over the configuration port, which is always ready, and should
// only be changed while no request is in flight.
module char_lcd_nibble_sequencer import lcdns_pkg::*; #(
  parameter int unsigned QueueDepth = LcdnsQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  lcdns_in_t          in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output lcdns_out_t         out_data_o,
  input  logic               out_stall_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HoldW-1:0]   cfg_data_i
);

  lcdns_cfg_t cfg_q;
  logic       push;
  lcdns_job_t push_data;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  lcdns_job_t head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_us          <= PulseResetUs;
      cfg_q.command_settle_us <= CmdSettleResetUs;
      cfg_q.data_settle_us    <= DataSettleResetUs;
      cfg_q.power_up_us       <= PowerUpResetUs;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgIdxPulse:      cfg_q.pulse_us          <= cfg_data_i;
        CfgIdxCmdSettle:  cfg_q.command_settle_us <= cfg_data_i;
        CfgIdxDataSettle: cfg_q.data_settle_us    <= cfg_data_i;
        CfgIdxPowerUp:    cfg_q.power_up_us       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lcdns_front u_front (
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  lcdns_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  lcdns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (!q_empty),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

/* hdl/lcdns_checker.sv */
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer port checker
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
module lcdns_checker import lcdns_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input lcdns_out_t out_data_o,
  input logic       out_stall_i
);

  property p_valid_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o;
  endproperty
  a_valid_holds: assert property (p_valid_holds)
    else $error("output word withdrawn while stalled");

  property p_data_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> $stable(out_data_o);
  endproperty
  a_data_holds: assert property (p_data_holds)
    else $error("output word changed while stalled");

  // An enable pulse is never the closing segment of a request.
  property p_pulse_not_last;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_stall_i && out_data_o.enable |-> !out_data_o.last;
  endproperty
  a_pulse_not_last: assert property (p_pulse_not_last)
    else $error("enable pulse marked as last segment");

  // The gap after an enable pulse follows in the very next cycle.
  property p_pulse_followed;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_stall_i && out_data_o.enable |=> out_valid_o;
  endproperty
  a_pulse_followed: assert property (p_pulse_followed)
    else $error("segment after enable pulse not ready in time");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_data_o  (out_data_o),
  .out_stall_i (out_stall_i)
);

/* dv/tb_char_lcd_nibble_sequencer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer testbench
// Sends initialise, command and data requests, with the unused mode mixed in,
// and predicts every pin segment in a scoreboard. The timing registers are
// rewritten between phases with zero, one, full-scale and random values.
// Both channels idle and stall in random bursts. The last phase runs at
// full rate.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer;
  import lcdns_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int IdleLimit   = 400;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 430;
  localparam int Phases      = 5;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  // Power-on timing values, microseconds.
  localparam logic [HoldW-1:0] PulseUsAtReset      = 16'd40;
  localparam logic [HoldW-1:0] CmdSettleUsAtReset  = 16'd5000;
  localparam logic [HoldW-1:0] DataSettleUsAtReset = 16'd2000;
  localparam logic [HoldW-1:0] PowerUpUsAtReset    = 16'd20000;

  // Four-bit set-up commands, first one in the top byte.
  localparam logic [47:0] SetupBytes = 48'h33_33_32_28_0C_01;

  class lcd_segment_tracker;
    lcdns_cfg_t timing;
    lcdns_out_t pending_segs[$];
    int         errors;

    function new();
      timing.pulse_us          = PulseUsAtReset;
      timing.command_settle_us = CmdSettleUsAtReset;
      timing.data_settle_us    = DataSettleUsAtReset;
      timing.power_up_us       = PowerUpUsAtReset;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [HoldW-1:0] val);
      case (idx)
        CfgIdxPulse:      timing.pulse_us = val;
        CfgIdxCmdSettle:  timing.command_settle_us = val;
        CfgIdxDataSettle: timing.data_settle_us = val;
        CfgIdxPowerUp:    timing.power_up_us = val;
        default: ;
      endcase
    endfunction

    function void add_seg(logic rs, logic en, logic [NibW-1:0] nib,
                          logic [HoldW-1:0] hold, logic last);
      lcdns_out_t seg;
      seg.reg_select = rs;
      seg.enable     = en;
      seg.nibble     = nib;
      seg.hold_us    = hold;
      seg.last       = last;
      pending_segs.push_back(seg);
    endfunction

    function void add_byte(logic rs, logic [ByteW-1:0] b, logic [HoldW-1:0] settle,
                           logic last);
      add_seg(rs, 1'b1, b[7:4], timing.pulse_us, 1'b0);
      add_seg(rs, 1'b0, b[7:4], timing.pulse_us, 1'b0);
      add_seg(rs, 1'b1, b[3:0], timing.pulse_us, 1'b0);
      add_seg(rs, 1'b0, b[3:0], settle, last);
    endfunction

    function void note_request(lcdns_in_t req);
      case (req.mode)
        MODE_INIT: begin
          add_seg(1'b0, 1'b0, 4'h0, timing.power_up_us, 1'b0);
          for (int i = 0; i < 6; i++) begin
            add_byte(1'b0, SetupBytes[47 - 8*i -: 8], timing.command_settle_us, 1'b0);
          end
          // The clear wait keeps the pins of the clear command's low nibble.
          add_seg(1'b0, 1'b0, SetupBytes[3:0], timing.power_up_us, 1'b1);
        end
        MODE_CMD:  add_byte(1'b0, req.byte_value, timing.command_settle_us, 1'b1);
        MODE_DATA: add_byte(1'b1, req.byte_value, timing.data_settle_us, 1'b1);
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_segs.size();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_segment(lcdns_out_t got);
      lcdns_out_t want;
      if (pending_segs.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        return;
      end
      want = pending_segs.pop_front();
      compare_field("reg_select", want.reg_select, got.reg_select);
      compare_field("enable", want.enable, got.enable);
      compare_field("nibble", want.nibble, got.nibble);
      compare_field("hold_us", want.hold_us, got.hold_us);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  lcdns_in_t          in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  lcdns_out_t         out_data;
  logic               out_stall = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [HoldW-1:0]   cfg_data  = '0;

  lcd_segment_tracker sb;
  int idle_cycles = 0;
  bit quiet       = 1'b0;
  int gap_odds    = 0;

  char_lcd_nibble_sequencer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Requests are noted before words are checked, so a same-edge pass-through
  // would still find its expectation.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_segment(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (rst_ni);
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Output stall in bursts, with an occasional long free-running stretch.
  initial begin
    int n;
    forever begin
      if (quiet) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        n = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 20);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b0;
        end
        n = $urandom_range(1, 12);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_request(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] b);
    lcdns_in_t req;
    req.mode       = mode;
    req.byte_value = b;
    if (!quiet && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
      idle_input($urandom_range(1, 12));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [HoldW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [HoldW-1:0] pulse, input logic [HoldW-1:0] cmd,
                            input logic [HoldW-1:0] data, input logic [HoldW-1:0] pwr);
    write_cfg(CfgIdxPulse, pulse);
    write_cfg(CfgIdxCmdSettle, cmd);
    write_cfg(CfgIdxDataSettle, data);
    write_cfg(CfgIdxPowerUp, pwr);
  endtask

  // An unused-mode request yields no word and is dropped as soon as it is
  // taken; the extra cycles run on after the last expected word.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [HoldW-1:0] pick_timing();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return HoldW'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int r;
    logic [ModeW-1:0] mode;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed part at the power-on timing.
    gap_odds = 2;
    send_request(MODE_INIT, 8'h00);
    send_request(MODE_CMD, 8'h00);
    send_request(MODE_CMD, 8'hFF);
    send_request(MODE_DATA, 8'h00);
    send_request(MODE_DATA, 8'hFF);
    send_request(ModeUnused, 8'hFF);
    send_request(ModeUnused, 8'h00);
    send_request(MODE_DATA, 8'h5A);
    send_request(MODE_CMD, 8'hA5);
    drain();

    // Full-scale timing, plus writes to indexes that do not exist.
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_cfg(8'd4, 16'h1234);
    write_cfg(8'hFF, 16'h0000);
    send_request(MODE_INIT, 8'hFF);
    send_request(MODE_CMD, 8'h3C);
    send_request(MODE_DATA, 8'hC3);
    drain();

    // A register written as zero is used as it stands.
    set_timing(16'd0, 16'd0, 16'd0, 16'd0);
    send_request(MODE_INIT, 8'h00);
    send_request(MODE_DATA, 8'h81);
    send_request(MODE_CMD, 8'h7E);
    drain();

    set_timing(16'd1, 16'd1, 16'd1, 16'd1);
    send_request(MODE_CMD, 8'h12);
    send_request(MODE_DATA, 8'hED);
    send_request(MODE_INIT, 8'h55);
    drain();

    for (int phase = 0; phase < Phases; phase++) begin
      quiet    = (phase == Phases - 1);
      gap_odds = $urandom_range(0, 4);
      set_timing(pick_timing(), pick_timing(), pick_timing(), pick_timing());
      if ($urandom_range(0, 2) == 0) begin
        write_cfg(CfgIdxW'($urandom_range(4, 255)), HoldW'($urandom_range(0, 65535)));
      end
      for (int i = 0; i < RandomItems / Phases; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10) mode = MODE_INIT;
        else if (r < 50) mode = MODE_CMD;
        else if (r < 92) mode = MODE_DATA;
        else mode = ModeUnused;
        send_request(mode, ByteW'($urandom_range(0, 255)));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lcdns_pkg.sv
hdl/lcdns_front.sv
hdl/lcdns_queue.sv
hdl/lcdns_back.sv
hdl/char_lcd_nibble_sequencer.sv
hdl/lcdns_checker.sv
dv/tb_char_lcd_nibble_sequencer.sv
